// File: src/bfba_pkg.sv
package bfba_pkg;

    localparam int KIND_W = 2;

    typedef logic [KIND_W-1:0] t_kind;
    typedef logic [7:0]        t_block_idx;

    localparam t_kind KIND_FIND = 2'd0;
    localparam t_kind KIND_USED = 2'd1;
    localparam t_kind KIND_FREE = 2'd2;

endpackage

// File: src/bitmap_free_block_allocator.sv
// Free-block bitmap allocator, one used bit per block, held in a small word memory of up to
// 64 bits a word with one valid flag per word, so after reset every block below
// FIRST_DATA_BLOCK reads as used and every other block as free, with no clearing pass.
// Kind 1 marks a block used and kind 2 marks it free. Each mark is a read-modify-write of one
// word (read, then write), followed by one acknowledgement with found set when the
// block is in range. Kind 0 scans upward from FIRST_DATA_BLOCK and returns up to request_count
// (saturated to MAX_REQUEST) free block indices, one transfer each, last set on the final one.
// The map is not changed. Each word is read, loaded and then encoded. One shared
// priority encoder then yields the free bits one at a time; each result waits until its
// output transfer is taken. If nothing is found, one result comes back with found
// clear. Input is not ready while an item is in progress.
module bitmap_free_block_allocator #(
    parameter int NUM_BLOCKS       = 256,
    parameter int MAX_REQUEST      = 16,
    parameter int FIRST_DATA_BLOCK = 2
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  bfba_pkg::t_kind       i_kind,
    input  bfba_pkg::t_block_idx  i_block_index,
    input  logic [4:0]            i_request_count,
    output logic                  o_valid,
    input  logic                  i_ready,
    output bfba_pkg::t_block_idx  o_found_index,
    output logic                  o_found,
    output logic                  o_last
);

    localparam int WORD_W    = (NUM_BLOCKS >= 64) ? 64 : 2 ** $clog2(NUM_BLOCKS);
    localparam int BIT_W     = $clog2(WORD_W);
    localparam int NUM_WORDS = (NUM_BLOCKS + WORD_W - 1) / WORD_W;
    localparam int ADDR_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int GIDX_W    = ADDR_W + BIT_W;
    localparam int REQ_W     = $clog2(MAX_REQUEST + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MRD,
        S_MWR,
        S_FRD,
        S_FLD,
        S_FSC,
        S_OUT
    } t_state;

    t_state              r_state;
    logic                r_done;
    bfba_pkg::t_kind     r_kind;
    logic                r_in_range;
    logic [ADDR_W-1:0]   r_addr;
    logic [BIT_W-1:0]    r_bit;
    logic [WORD_W-1:0]   r_word;
    logic [REQ_W-1:0]    r_want;
    logic [REQ_W-1:0]    r_hits;
    logic                r_have_pend;
    logic [GIDX_W-1:0]   r_pend;

    logic [WORD_W-1:0]   mem [NUM_WORDS];
    logic [NUM_WORDS-1:0] r_vld;
    logic [WORD_W-1:0]   r_rd_data;
    logic                r_rd_vld;

    logic [GIDX_W-1:0]   w_in_gidx;
    logic [REQ_W-1:0]    w_want;
    logic [WORD_W-1:0]   w_rst_word;
    logic [WORD_W-1:0]   w_fixed;
    logic [WORD_W-1:0]   w_rd_word;
    logic [WORD_W-1:0]   w_wdata;
    logic                w_we;
    logic                w_hit;
    logic [BIT_W-1:0]    w_pos;
    logic [GIDX_W-1:0]   w_hit_gidx;
    logic [REQ_W-1:0]    n_hits;

    assign o_ready   = (r_state == S_IDLE);
    assign w_in_gidx = GIDX_W'(i_block_index);

    always_comb begin
        if (32'(i_request_count) > MAX_REQUEST) begin
            w_want = REQ_W'(MAX_REQUEST);
        end else begin
            w_want = REQ_W'(i_request_count);
        end
    end

    // per-bit constants of the addressed word: reset value and bits never allocatable
    always_comb begin
        for (int b = 0; b < WORD_W; b++) begin
            w_rst_word[b] = (32'({r_addr, BIT_W'(b)}) < FIRST_DATA_BLOCK);
            w_fixed[b]    = w_rst_word[b] || (32'({r_addr, BIT_W'(b)}) >= NUM_BLOCKS);
        end
    end

    assign w_rd_word = r_rd_vld ? r_rd_data : w_rst_word;

    always_comb begin
        w_wdata        = w_rd_word;
        w_wdata[r_bit] = (r_kind == bfba_pkg::KIND_USED);
    end

    assign w_we = (r_state == S_MWR) && r_in_range;

    // shared priority encoder: lowest clear bit of the working word
    always_comb begin
        w_pos = '0;
        for (int b = WORD_W - 1; b >= 0; b--) begin
            if (!r_word[b]) begin
                w_pos = BIT_W'(b);
            end
        end
    end

    assign w_hit      = ~&r_word;
    assign w_hit_gidx = {r_addr, w_pos};
    assign n_hits     = r_hits + REQ_W'(1);

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[r_addr] <= w_wdata;
        end
        r_rd_data <= mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (w_we) begin
                r_vld[r_addr] <= 1'b1;
            end
            r_rd_vld <= r_vld[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_valid <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_kind      <= i_kind;
                        r_in_range  <= (32'(i_block_index) < NUM_BLOCKS);
                        r_hits      <= '0;
                        r_want      <= w_want;
                        r_have_pend <= 1'b0;
                        if (i_kind == bfba_pkg::KIND_USED || i_kind == bfba_pkg::KIND_FREE) begin
                            r_addr  <= w_in_gidx[GIDX_W-1:BIT_W];
                            r_bit   <= w_in_gidx[BIT_W-1:0];
                            r_state <= S_MRD;
                        end else if (i_kind == bfba_pkg::KIND_FIND && w_want != '0) begin
                            r_addr  <= ADDR_W'(FIRST_DATA_BLOCK / WORD_W);
                            r_state <= S_FRD;
                        end else begin
                            o_found_index <= '0;
                            o_found       <= 1'b0;
                            o_last        <= 1'b1;
                            o_valid       <= 1'b1;
                            r_done        <= 1'b1;
                            r_state       <= S_OUT;
                        end
                        if (i_kind == bfba_pkg::KIND_USED || i_kind == bfba_pkg::KIND_FREE) begin
                            o_found_index <= i_block_index;
                        end
                    end
                end
                S_MRD: begin
                    r_state <= S_MWR;
                end
                S_MWR: begin
                    o_found <= r_in_range;
                    o_last  <= 1'b1;
                    o_valid <= 1'b1;
                    r_done  <= 1'b1;
                    r_state <= S_OUT;
                end
                S_FRD: begin
                    r_state <= S_FLD;
                end
                S_FLD: begin
                    r_word  <= w_rd_word | w_fixed;
                    r_state <= S_FSC;
                end
                S_FSC: begin
                    if (r_hits == r_want) begin
                        // request met: the held final hit goes out last
                        o_found_index <= 8'(r_pend);
                        o_found       <= 1'b1;
                        o_last        <= 1'b1;
                        o_valid       <= 1'b1;
                        r_done        <= 1'b1;
                        r_state       <= S_OUT;
                    end else if (w_hit) begin
                        r_word[w_pos] <= 1'b1;
                        r_hits        <= n_hits;
                        if (n_hits == r_want && !r_have_pend) begin
                            o_found_index <= 8'(w_hit_gidx);
                            o_found       <= 1'b1;
                            o_last        <= 1'b1;
                            o_valid       <= 1'b1;
                            r_done        <= 1'b1;
                            r_state       <= S_OUT;
                        end else begin
                            r_pend      <= w_hit_gidx;
                            r_have_pend <= 1'b1;
                            if (r_have_pend) begin
                                o_found_index <= 8'(r_pend);
                                o_found       <= 1'b1;
                                o_last        <= 1'b0;
                                o_valid       <= 1'b1;
                                r_done        <= 1'b0;
                                r_state       <= S_OUT;
                            end
                        end
                    end else if (r_addr != ADDR_W'(NUM_WORDS - 1)) begin
                        r_addr  <= r_addr + ADDR_W'(1);
                        r_state <= S_FRD;
                    end else begin
                        o_found_index <= r_have_pend ? 8'(r_pend) : '0;
                        o_found       <= r_have_pend;
                        o_last        <= 1'b1;
                        o_valid       <= 1'b1;
                        r_done        <= 1'b1;
                        r_state       <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (i_ready) begin
                        o_valid <= 1'b0;
                        r_state <= r_done ? S_IDLE : S_FSC;
                    end
                end
                default: begin
                    o_valid <= 1'b0;
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
